// ===== hw/rtl/cs_pkg.sv =====
// Shared types and constants for the cluster sphericity block.
// No dependencies; cs_front, cs_back and cluster_sphericity_core import this package.
package cs_pkg;

    localparam int CFG_W  = 13;   // row width register
    localparam int COL_W  = 13;   // column within a row
    localparam int FRAC_W = 8;    // fraction bits of centroid and radius
    localparam int DQ_W   = 22;   // clamped coordinate difference, Q.8
    localparam int SQ_W   = 44;   // sum of two squared differences, Q.16
    localparam int ROOT_W = 22;   // square root of SQ_W bits
    localparam int DIV_W  = 64;   // shared long divider
    localparam int SPH_W  = 24;
    localparam int RAD_W  = 21;
    localparam int CEN_W  = 20;
    localparam int TOT_W  = 11;

    localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 13'd2048;
    localparam logic [DQ_W-1:0]  DIFF_CLAMP      = 22'h200000;
    localparam logic [FRAC_W-1:0] HALF_PIXEL     = 8'd128;
    localparam logic [14:0]      PI_NUM          = 15'd31415;
    localparam logic [13:0]      PI_DEN          = 14'd10000;
    localparam logic [SPH_W-1:0] SPH_MAX         = 24'hFFFFFF;
    localparam logic [RAD_W-1:0] RAD_MAX         = 21'h1FFFFF;
    localparam logic [CEN_W-1:0] CEN_MAX         = 20'hFFFFF;

    typedef struct packed {
        logic             status;
        logic [TOT_W-1:0] pixel_total;
        logic [CEN_W-1:0] center_row;
        logic [CEN_W-1:0] center_col;
        logic [RAD_W-1:0] max_radius;
        logic [SPH_W-1:0] sphericity;
    } cs_result_t;

endpackage

// ===== hw/rtl/cs_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters; used by the front and back ends.
module cs_divider #(
    parameter int N_W = 24,
    parameter int D_W = 13
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic           done,
    output logic [N_W-1:0] quo,
    output logic [D_W-1:0] rem
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   num_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D_W:0]     partial;
    logic             fits;

    assign partial = {rem_reg, num_reg[N_W-1]};
    assign fits    = partial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[N_W-2:0], fits};
            rem_reg <= fits ? D_W'(partial - {1'b0, den_reg}) : D_W'(partial);
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;
    assign rem  = rem_reg;
endmodule

// ===== hw/rtl/cs_isqrt.sv =====
// Integer square root, one result bit per cycle (two operand bits a step).
// Depends on nothing but its parameter.
module cs_isqrt #(
    parameter int R_W = 22
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [2*R_W-1:0] value,
    output logic             done,
    output logic [R_W-1:0]   root
);
    localparam int V_W   = 2 * R_W;
    localparam int CNT_W = $clog2(R_W + 1);

    logic [V_W-1:0]   val_reg;
    logic [R_W+2:0]   rem_reg;
    logic [R_W-1:0]   root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [R_W+2:0]   rem_sh;
    logic [R_W+2:0]   trial;
    logic             take;

    assign rem_sh = {rem_reg[R_W:0], val_reg[V_W-1:V_W-2]};
    assign trial  = (R_W+3)'({root_reg, 2'b01});
    assign take   = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(R_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            val_reg  <= {val_reg[V_W-3:0], 2'b00};
            rem_reg  <= take ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[R_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ===== hw/rtl/cs_fifo.sv =====
// Small register queue between the front and back ends.
// Depends on nothing but its parameters.
module cs_fifo #(
    parameter int W     = 38,
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [W-1:0]     entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;
    logic             push;
    logic             pop;

    assign push_ready = level_reg != LVL_W'(DEPTH);
    assign pop_valid  = level_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                level_reg <= level_reg + 1'b1;
            end else if (pop && !push) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ===== hw/rtl/cs_front.sv =====
// Front end: accepts pixel beats and splits each index into column and row.
// Depends on cs_pkg and cs_divider.
module cs_front
    import cs_pkg::*;
#(
    parameter int INDEX_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [INDEX_BITS-1:0] in_index,
    input  logic                  in_last,
    input  logic [CFG_W-1:0]      row_width,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COL_W-1:0]      out_col,
    output logic [INDEX_BITS-1:0] out_row,
    output logic                  out_last
);
    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_DIV  = 2'd1;
    localparam logic [1:0] FS_HOLD = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic             last_reg;
    logic             accept;
    logic             div_done;
    logic [CFG_W-1:0] width_eff;

    assign in_ready  = state_reg == FS_IDLE;
    assign accept    = in_valid && in_ready;
    assign out_valid = state_reg == FS_HOLD;
    assign out_last  = last_reg;
    // A zero row width behaves as a width of one.
    assign width_eff = (row_width == '0) ? CFG_W'(1) : row_width;

    cs_divider #(
        .N_W(INDEX_BITS),
        .D_W(COL_W)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (accept),
        .num    (in_index),
        .den    (width_eff),
        .done   (div_done),
        .quo    (out_row),
        .rem    (out_col)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FS_IDLE: if (accept) state_next = FS_DIV;
            FS_DIV:  if (div_done) state_next = FS_HOLD;
            FS_HOLD: if (out_ready) state_next = FS_IDLE;
            default: state_next = FS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            last_reg <= in_last;
        end
    end
endmodule

// ===== hw/rtl/cs_back.sv =====
// Back end: stores and sums pixels, then on the last pixel forms centroid,
// radius and sphericity. Depends on cs_pkg, cs_divider and cs_isqrt.
module cs_back
    import cs_pkg::*;
#(
    parameter int INDEX_BITS = 24,
    parameter int MAX_PIXELS = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COL_W-1:0]      in_col,
    input  logic [INDEX_BITS-1:0] in_row,
    input  logic                  in_last,
    output logic                  res_valid,
    input  logic                  res_ready,
    output cs_result_t            res
);
    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CSUM_W = COL_W + CNT_W;
    localparam int RSUM_W = INDEX_BITS + CNT_W;
    localparam int CQ_W   = COL_W + FRAC_W;
    localparam int RQ_W   = INDEX_BITS + FRAC_W;
    localparam int RP_W   = (RQ_W + 1 > DQ_W) ? RQ_W + 1 : DQ_W;
    localparam int MEM_W  = COL_W + INDEX_BITS;

    localparam logic [3:0] BS_LOAD      = 4'd0;
    localparam logic [3:0] BS_CX_GO     = 4'd1;
    localparam logic [3:0] BS_CX_WAIT   = 4'd2;
    localparam logic [3:0] BS_CY_GO     = 4'd3;
    localparam logic [3:0] BS_CY_WAIT   = 4'd4;
    localparam logic [3:0] BS_SCAN      = 4'd5;
    localparam logic [3:0] BS_ROOT_GO   = 4'd6;
    localparam logic [3:0] BS_ROOT_WAIT = 4'd7;
    localparam logic [3:0] BS_MUL1      = 4'd8;
    localparam logic [3:0] BS_MUL2      = 4'd9;
    localparam logic [3:0] BS_SPH_GO    = 4'd10;
    localparam logic [3:0] BS_SPH_WAIT  = 4'd11;
    localparam logic [3:0] BS_OUT       = 4'd12;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [MEM_W-1:0]  mem [MAX_PIXELS];
    logic [CNT_W-1:0]  count_reg;
    logic [CSUM_W-1:0] col_sum_reg;
    logic [RSUM_W-1:0] row_sum_reg;
    logic              ovf_reg;
    logic [CQ_W-1:0]   cx_reg;
    logic [RQ_W-1:0]   cy_reg;
    logic [CNT_W-1:0]  scan_addr_reg;
    logic [MEM_W-1:0]  rd_data_reg;
    logic              v1_reg, v2_reg, v3_reg;
    logic [DQ_W-1:0]   dx_reg, dy_reg;
    logic [SQ_W-1:0]   sqx_reg, sqy_reg;
    logic [SQ_W-1:0]   best_reg;
    logic [RAD_W-1:0]  r_reg;
    logic [2*RAD_W-1:0] rr_reg;
    logic [DIV_W-1:0]  numer_reg;
    logic [DIV_W-1:0]  denom_reg;
    logic [SPH_W-1:0]  sph_reg;
    logic              res_valid_reg;
    cs_result_t        res_reg;

    logic              pop;
    logic              store;
    logic              rd_en;
    logic              scan_done;
    logic              div_start;
    logic [DIV_W-1:0]  div_num;
    logic [DIV_W-1:0]  div_den;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;
    logic [DIV_W-1:0]  div_rem;
    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;
    logic [CQ_W-1:0]   col_q;
    logic [RQ_W-1:0]   row_q;
    logic [CQ_W-1:0]   col_mag;
    logic [RQ_W-1:0]   row_mag;
    logic [DQ_W-1:0]   col_p;
    logic [RP_W-1:0]   row_p;
    logic [SQ_W-1:0]   dist2;
    logic [CNT_W+13:0] cnt_scaled;
    logic              out_free;

    assign in_ready  = state_reg == BS_LOAD;
    assign pop       = in_valid && in_ready;
    assign store     = pop && (count_reg != CNT_W'(MAX_PIXELS));
    assign rd_en     = (state_reg == BS_SCAN) && (scan_addr_reg != count_reg);
    assign scan_done = (state_reg == BS_SCAN) && (scan_addr_reg == count_reg)
                       && !v1_reg && !v2_reg && !v3_reg;
    assign out_free  = !res_valid_reg || res_ready;
    assign div_start = (state_reg == BS_CX_GO) || (state_reg == BS_CY_GO)
                       || (state_reg == BS_SPH_GO);

    always_comb begin
        case (state_reg)
            BS_CX_GO: begin
                div_num = DIV_W'({col_sum_reg, {FRAC_W{1'b0}}});
                div_den = DIV_W'(count_reg);
            end
            BS_CY_GO: begin
                div_num = DIV_W'({row_sum_reg, {FRAC_W{1'b0}}});
                div_den = DIV_W'(count_reg);
            end
            default: begin
                div_num = numer_reg;
                div_den = denom_reg;
            end
        endcase
    end

    cs_divider #(
        .N_W(DIV_W),
        .D_W(DIV_W)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quo    (div_quo),
        .rem    (div_rem)
    );

    cs_isqrt #(
        .R_W(ROOT_W)
    ) u_sqrt (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (state_reg == BS_ROOT_GO),
        .value  (best_reg),
        .done   (sqrt_done),
        .root   (sqrt_root)
    );

    // The farthest corner on each axis lies half a pixel beyond the center
    // distance, so one clamped difference per axis covers all four corners.
    assign col_q   = {rd_data_reg[COL_W-1:0], {FRAC_W{1'b0}}};
    assign row_q   = {rd_data_reg[MEM_W-1:COL_W], {FRAC_W{1'b0}}};
    assign col_mag = (col_q >= cx_reg) ? col_q - cx_reg : cx_reg - col_q;
    assign row_mag = (row_q >= cy_reg) ? row_q - cy_reg : cy_reg - row_q;
    assign col_p   = DQ_W'(col_mag) + DQ_W'(HALF_PIXEL);
    assign row_p   = RP_W'(row_mag) + RP_W'(HALF_PIXEL);
    assign dist2   = sqx_reg + sqy_reg;
    assign cnt_scaled = count_reg * PI_DEN;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BS_LOAD:      if (pop && in_last) state_next = BS_CX_GO;
            BS_CX_GO:     state_next = BS_CX_WAIT;
            BS_CX_WAIT:   if (div_done) state_next = BS_CY_GO;
            BS_CY_GO:     state_next = BS_CY_WAIT;
            BS_CY_WAIT:   if (div_done) state_next = BS_SCAN;
            BS_SCAN:      if (scan_done) state_next = BS_ROOT_GO;
            BS_ROOT_GO:   state_next = BS_ROOT_WAIT;
            BS_ROOT_WAIT: if (sqrt_done) state_next = BS_MUL1;
            BS_MUL1:      state_next = (r_reg == '0) ? BS_OUT : BS_MUL2;
            BS_MUL2:      state_next = BS_SPH_GO;
            BS_SPH_GO:    state_next = BS_SPH_WAIT;
            BS_SPH_WAIT:  if (div_done) state_next = BS_OUT;
            BS_OUT:       if (out_free) state_next = BS_LOAD;
            default:      state_next = BS_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BS_LOAD;
            count_reg     <= '0;
            col_sum_reg   <= '0;
            row_sum_reg   <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            scan_addr_reg <= '0;
            best_reg      <= '0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= rd_en;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            if (res_valid_reg && res_ready) begin
                res_valid_reg <= 1'b0;
            end
            if (store) begin
                count_reg   <= count_reg + 1'b1;
                col_sum_reg <= col_sum_reg + CSUM_W'(in_col);
                row_sum_reg <= row_sum_reg + RSUM_W'(in_row);
            end else if (pop) begin
                ovf_reg <= 1'b1;
            end
            if (rd_en) begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
            if (v3_reg && dist2 > best_reg) begin
                best_reg <= dist2;
            end
            if (state_reg == BS_OUT && out_free) begin
                res_valid_reg <= 1'b1;
                count_reg     <= '0;
                col_sum_reg   <= '0;
                row_sum_reg   <= '0;
                ovf_reg       <= 1'b0;
                scan_addr_reg <= '0;
                best_reg      <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (store) begin
            mem[count_reg[ADDR_W-1:0]] <= {in_row, in_col};
        end
        if (rd_en) begin
            rd_data_reg <= mem[scan_addr_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == BS_CX_WAIT && div_done) begin
            cx_reg <= CQ_W'(div_quo);
        end
        if (state_reg == BS_CY_WAIT && div_done) begin
            cy_reg <= RQ_W'(div_quo);
        end
        dx_reg  <= (col_p > DIFF_CLAMP) ? DIFF_CLAMP : col_p;
        dy_reg  <= (row_p > RP_W'(DIFF_CLAMP)) ? DIFF_CLAMP : DQ_W'(row_p);
        sqx_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        if (sqrt_done) begin
            r_reg <= (sqrt_root > ROOT_W'(RAD_MAX)) ? RAD_MAX : RAD_W'(sqrt_root);
        end
        if (state_reg == BS_MUL1) begin
            rr_reg    <= (2*RAD_W)'(r_reg) * (2*RAD_W)'(r_reg);
            numer_reg <= DIV_W'(cnt_scaled) << 32;
            sph_reg   <= ((DIV_W'(count_reg) << 16) > DIV_W'(SPH_MAX))
                         ? SPH_MAX : SPH_W'(DIV_W'(count_reg) << 16);
        end
        if (state_reg == BS_MUL2) begin
            denom_reg <= DIV_W'(rr_reg) * DIV_W'(PI_NUM);
        end
        if (state_reg == BS_SPH_WAIT && div_done) begin
            sph_reg <= (div_quo > DIV_W'(SPH_MAX)) ? SPH_MAX : SPH_W'(div_quo);
        end
        if (state_reg == BS_OUT && out_free) begin
            res_reg.status      <= ovf_reg;
            res_reg.pixel_total <= TOT_W'(count_reg);
            res_reg.center_row  <= (DIV_W'(cy_reg) > DIV_W'(CEN_MAX))
                                   ? CEN_MAX : CEN_W'(cy_reg);
            res_reg.center_col  <= (DIV_W'(cx_reg) > DIV_W'(CEN_MAX))
                                   ? CEN_MAX : CEN_W'(cx_reg);
            res_reg.max_radius  <= r_reg;
            res_reg.sphericity  <= sph_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
endmodule

// ===== hw/rtl/cluster_sphericity_core.sv =====
// Cluster sphericity core: one pixel index per input beat, one result beat per cluster.
// In the front end each pixel passes through a one-bit-per-cycle divider that splits
// the index into row and column; the back end then stores it. On the beat with tlast
// the back end adds two centroid divisions, a pipelined pass over the pixel memory at
// one pixel per cycle, a square root and, unless the radius is zero, a sphericity
// division, the divisions all in one shared divider. New pixels are taken while a
// finished result waits on m_axis.
module cluster_sphericity_core
    import cs_pkg::*;
#(
    parameter int MAX_PIXELS = 1024,
    parameter int INDEX_BITS = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [INDEX_BITS-1:0] pixel_index, zero padded to whole bytes
    input  logic [((INDEX_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [23:0] sphericity, [44:24] max_radius, [64:45] center_col,
    // [84:65] center_row, [95:85] pixel_total
    output logic [95:0]                     m_axis_tdata,
    // [0] status
    output logic                            m_axis_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [CFG_W-1:0]                cfg_data
);
    localparam int Q_W = COL_W + INDEX_BITS + 1;

    logic [CFG_W-1:0]      row_width_reg;
    logic                  f_valid, f_ready, f_last;
    logic [COL_W-1:0]      f_col;
    logic [INDEX_BITS-1:0] f_row;
    logic                  q_valid, q_ready;
    logic [Q_W-1:0]        q_data;
    cs_result_t            res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ROW_WIDTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            row_width_reg <= cfg_data;
        end
    end

    cs_front #(
        .INDEX_BITS(INDEX_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_index (s_axis_tdata[INDEX_BITS-1:0]),
        .in_last  (s_axis_tlast),
        .row_width(row_width_reg),
        .out_valid(f_valid),
        .out_ready(f_ready),
        .out_col  (f_col),
        .out_row  (f_row),
        .out_last (f_last)
    );

    cs_fifo #(
        .W    (Q_W),
        .DEPTH(2)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(f_valid),
        .push_ready(f_ready),
        .push_data ({f_last, f_row, f_col}),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_data  (q_data)
    );

    cs_back #(
        .INDEX_BITS(INDEX_BITS),
        .MAX_PIXELS(MAX_PIXELS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_col   (q_data[COL_W-1:0]),
        .in_row   (q_data[Q_W-2:COL_W]),
        .in_last  (q_data[Q_W-1]),
        .res_valid(m_axis_tvalid),
        .res_ready(m_axis_tready),
        .res      (res)
    );

    assign m_axis_tdata = {res.pixel_total, res.center_row, res.center_col,
                           res.max_radius, res.sphericity};
    assign m_axis_tuser = res.status;

    // The front end divides each accepted beat over many cycles.
    a_front_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("front end took two beats in a row");

    // A result beat holds still while the sink stalls.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");
endmodule
